// File: hw/rtl/cylinder_support_point_defines.svh
// assertion macros shared by the cylinder support point rtl
// no dependencies; included by files that carry assertions
`ifndef CYLINDER_SUPPORT_POINT_DEFINES_SVH
`define CYLINDER_SUPPORT_POINT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csp check failed");

// next-cycle implication, disabled during reset
`define CSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csp check failed");

`endif

// File: hw/rtl/csp_pkg.sv
// shared types for the cylinder support point pipeline
// no dependencies
package csp_pkg;

    localparam int WordW  = 32;
    localparam int SqrtW  = 64;
    localparam int RemW   = 36;
    localparam int QuotW  = 31;
    localparam int ProdW  = 63;
    localparam int SqSteps  = 32;
    localparam int DivSteps = 31;

    // payload of one item inside the square-root chain
    typedef struct packed {
        logic [SqrtW-1:0] n;
        logic [RemW-1:0]  rem;
        logic [WordW-1:0] root;
        logic [ProdW-1:0] dx;
        logic [ProdW-1:0] dz;
        logic             nx;
        logic             nz;
        logic [WordW-1:0] py;
    } t_sq;

    // payload of one item inside the divider chain
    typedef struct packed {
        logic [WordW-1:0] rem_x;
        logic [WordW-1:0] rem_z;
        logic [QuotW-1:0] d_x;
        logic [QuotW-1:0] d_z;
        logic [QuotW-1:0] q_x;
        logic [QuotW-1:0] q_z;
        logic [WordW-1:0] sigma;
        logic             nx;
        logic             nz;
        logic [WordW-1:0] py;
    } t_div;

endpackage

// File: hw/rtl/csp_sqrt_cell.sv
// one step of the bit-pair restoring square root
// depends on csp_pkg
module csp_sqrt_cell import csp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_sq  i_data,
    output logic o_valid,
    output t_sq  o_data
);
    logic       r_valid;
    t_sq        r_data;
    t_sq        n_data;
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;

    always_comb begin
        n_data = i_data;
        rem_sh = {i_data.rem[RemW-3:0], i_data.n[SqrtW-1 -: 2]};
        trial  = {{(RemW-WordW-2){1'b0}}, i_data.root, 2'b01};
        n_data.n = {i_data.n[SqrtW-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_data.rem  = rem_sh - trial;
            n_data.root = {i_data.root[WordW-2:0], 1'b1};
        end else begin
            n_data.rem  = rem_sh;
            n_data.root = {i_data.root[WordW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: hw/rtl/csp_div_cell.sv
// one restoring division step for both rim coordinates
// depends on csp_pkg
module csp_div_cell import csp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_data,
    output logic o_valid,
    output t_div o_data
);
    logic        r_valid;
    t_div        r_data;
    t_div        n_data;
    logic [WordW:0] sh_x;
    logic [WordW:0] sh_z;
    logic [WordW:0] dvs;

    always_comb begin
        n_data = i_data;
        dvs  = {1'b0, i_data.sigma};
        sh_x = {i_data.rem_x, i_data.d_x[QuotW-1]};
        sh_z = {i_data.rem_z, i_data.d_z[QuotW-1]};
        n_data.d_x = {i_data.d_x[QuotW-2:0], 1'b0};
        n_data.d_z = {i_data.d_z[QuotW-2:0], 1'b0};
        if (sh_x >= dvs) begin
            n_data.rem_x = WordW'(sh_x - dvs);
            n_data.q_x   = {i_data.q_x[QuotW-2:0], 1'b1};
        end else begin
            n_data.rem_x = sh_x[WordW-1:0];
            n_data.q_x   = {i_data.q_x[QuotW-2:0], 1'b0};
        end
        if (sh_z >= dvs) begin
            n_data.rem_z = WordW'(sh_z - dvs);
            n_data.q_z   = {i_data.q_z[QuotW-2:0], 1'b1};
        end else begin
            n_data.rem_z = sh_z[WordW-1:0];
            n_data.q_z   = {i_data.q_z[QuotW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: hw/rtl/cylinder_support_point.sv
// cylinder support point: gjk support mapping of a y-axis cylinder
// depends on csp_pkg, csp_sqrt_cell, csp_div_cell and the defines header
//
//  channel   dir  fields (low bit first)              handshake
//  s_axis    in   dir_x, dir_y, dir_z (96 bits)       tvalid/tready
//  m_axis    out  point_x, point_y, point_z (96 bits) tvalid/tready
//  apb       in   diameter @0x0, height @0x4          psel/penable, pready=1
//
// one item per cycle sustained while the output is not stalled; stages in order:
// magnitude, multiply, sum, 32 square-root cells, divider load, 31 divider cells, output register
// synchronous active-low reset clears all valid bits; registers go to 2.0
// the whole chain advances together; it stalls only when the output register
// is full and the sink holds tready low; no item is taken while in reset
`include "cylinder_support_point_defines.svh"
module cylinder_support_point import csp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [95:0]     i_s_axis_tdata,  // dir_x, dir_y, dir_z
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [95:0]     o_m_axis_tdata,  // point_x, point_y, point_z
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    // configuration registers
    logic [WordW-1:0] r_diam;
    logic [WordW-1:0] r_height;
    logic [QuotW-1:0] rad;
    logic [QuotW-1:0] half;

    assign rad    = r_diam[WordW-1:1];
    assign half   = r_height[WordW-1:1];
    assign pready = 1'b1;
    assign prdata = paddr[2] ? r_height : r_diam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diam   <= WordW'(32'h0002_0000);
            r_height <= WordW'(32'h0002_0000);
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_height <= pwdata;
            end else begin
                r_diam <= pwdata;
            end
        end
    end

    // global advance: everything moves unless the output is stuck
    logic en;
    logic r_out_valid;
    assign en = !r_out_valid || i_m_axis_tready;
    // input closed during reset so nothing is taken and then dropped
    assign o_s_axis_tready = en && i_rst_n;

    // stage a: magnitudes, signs and the y result
    logic             r_a_valid;
    logic [WordW-1:0] r_a_mx, r_a_mz;
    logic             r_a_nx, r_a_nz;
    logic [WordW-1:0] r_a_py;
    logic [WordW-1:0] in_x, in_y, in_z;

    assign in_x = i_s_axis_tdata[31:0];
    assign in_y = i_s_axis_tdata[63:32];
    assign in_z = i_s_axis_tdata[95:64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_s_axis_tvalid;
        end
        if (en) begin
            r_a_nx <= in_x[WordW-1];
            r_a_nz <= in_z[WordW-1];
            r_a_mx <= in_x[WordW-1] ? (~in_x + 1'b1) : in_x;
            r_a_mz <= in_z[WordW-1] ? (~in_z + 1'b1) : in_z;
            if (in_y == '0) begin
                r_a_py <= '0;
            end else if (in_y[WordW-1]) begin
                r_a_py <= ~{1'b0, half} + 1'b1;
            end else begin
                r_a_py <= {1'b0, half};
            end
        end
    end

    // stage b: squares and radius products
    logic             r_b_valid;
    logic [SqrtW-1:0] r_b_sx, r_b_sz;
    logic [ProdW-1:0] r_b_dx, r_b_dz;
    logic             r_b_nx, r_b_nz;
    logic [WordW-1:0] r_b_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
        if (en) begin
            r_b_sx <= r_a_mx * r_a_mx;
            r_b_sz <= r_a_mz * r_a_mz;
            r_b_dx <= rad * r_a_mx;
            r_b_dz <= rad * r_a_mz;
            r_b_nx <= r_a_nx;
            r_b_nz <= r_a_nz;
            r_b_py <= r_a_py;
        end
    end

    // stage c: square sum feeds the root chain
    logic r_c_valid;
    t_sq  r_c_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
        if (en) begin
            r_c_data.n    <= r_b_sx + r_b_sz;
            r_c_data.rem  <= '0;
            r_c_data.root <= '0;
            r_c_data.dx   <= r_b_dx;
            r_c_data.dz   <= r_b_dz;
            r_c_data.nx   <= r_b_nx;
            r_c_data.nz   <= r_b_nz;
            r_c_data.py   <= r_b_py;
        end
    end

    // square-root chain, two radicand bits per cell
    logic sq_valid [SqSteps+1];
    t_sq  sq_data  [SqSteps+1];
    assign sq_valid[0] = r_c_valid;
    assign sq_data[0]  = r_c_data;

    for (genvar g = 0; g < SqSteps; g++) begin : g_sq
        csp_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[g]),
            .i_data  (sq_data[g]),
            .o_valid (sq_valid[g+1]),
            .o_data  (sq_data[g+1])
        );
    end

    // divider load: top half of each product becomes the first remainder
    logic r_d_valid;
    t_div r_d_data;
    t_sq  sq_last;
    assign sq_last = sq_data[SqSteps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= sq_valid[SqSteps];
        end
        if (en) begin
            r_d_data.rem_x <= sq_last.dx[ProdW-1 -: WordW];
            r_d_data.rem_z <= sq_last.dz[ProdW-1 -: WordW];
            r_d_data.d_x   <= sq_last.dx[QuotW-1:0];
            r_d_data.d_z   <= sq_last.dz[QuotW-1:0];
            r_d_data.q_x   <= '0;
            r_d_data.q_z   <= '0;
            r_d_data.sigma <= sq_last.root;
            r_d_data.nx    <= sq_last.nx;
            r_d_data.nz    <= sq_last.nz;
            r_d_data.py    <= sq_last.py;
        end
    end

    // divider chain, one quotient bit per cell for x and z
    logic dv_valid [DivSteps+1];
    t_div dv_data  [DivSteps+1];
    assign dv_valid[0] = r_d_valid;
    assign dv_data[0]  = r_d_data;

    for (genvar g = 0; g < DivSteps; g++) begin : g_dv
        csp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[g]),
            .i_data  (dv_data[g]),
            .o_valid (dv_valid[g+1]),
            .o_data  (dv_data[g+1])
        );
    end

    // output register: clamp guard, sign and zero-direction case
    t_div             dv_last;
    logic [QuotW-1:0] cq_x, cq_z;
    logic [WordW-1:0] r_px, r_pz, r_py;
    assign dv_last = dv_data[DivSteps];
    assign cq_x = (dv_last.q_x > rad) ? rad : dv_last.q_x;
    assign cq_z = (dv_last.q_z > rad) ? rad : dv_last.q_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid[DivSteps];
        end
        if (en) begin
            r_py <= dv_last.py;
            if (dv_last.sigma == '0) begin
                r_px <= '0;
                r_pz <= '0;
            end else begin
                r_px <= dv_last.nx ? (~{1'b0, cq_x} + 1'b1) : {1'b0, cq_x};
                r_pz <= dv_last.nz ? (~{1'b0, cq_z} + 1'b1) : {1'b0, cq_z};
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_pz, r_py, r_px};

    // accepted item shows up in the first stage
    `CSP_ASSERT_NEXT(a_accept_to_stage, i_s_axis_tvalid && o_s_axis_tready, r_a_valid)
    // first remainder is below the divisor, so the quotient fits its width
    `CSP_ASSERT_NOW(a_div_start_x, r_d_valid && r_d_data.sigma != '0,
        r_d_data.rem_x < r_d_data.sigma)
    `CSP_ASSERT_NOW(a_div_start_z, r_d_valid && r_d_data.sigma != '0,
        r_d_data.rem_z < r_d_data.sigma)
    // quotient never reaches past the radius
    `CSP_ASSERT_NOW(a_quot_bound, dv_valid[DivSteps] && dv_last.sigma != '0,
        dv_last.q_x <= rad && dv_last.q_z <= rad)
endmodule

// File: verif/tb_cylinder_support_point.sv
// self-checking bench for the cylinder support point block
// depends on csp_pkg and cylinder_support_point; drives stream and apb ports
module tb_cylinder_support_point;
    import csp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] AddrDiameter = 3'h0;
    localparam logic [2:0] AddrHeight   = 3'h4;
    localparam int PipeLatency = 68;

    typedef struct packed {
        logic signed [WordW-1:0] z;
        logic signed [WordW-1:0] y;
        logic signed [WordW-1:0] x;
    } t_vec;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cylinder_support_point DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // dir_x, dir_y, dir_z
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // point_x, point_y, point_z
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // predictor copy of the two registers
    logic [31:0] cyl_diameter;
    logic [31:0] cyl_height;

    t_vec dir_queue[$];      // directions waiting to be sent
    t_vec point_queue[$];    // predicted support points
    int   n_errors;
    int   sent_count;
    int   hold_cycles;       // long receiver hold-off, counted by the monitor
    bit   hold_request;
    bit   s_accepted;        // input handshake seen at the last rising edge

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor square root of a 64-bit value, bit by bit
    function automatic logic [31:0] floor_root(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bitv;
        res  = '0;
        rem  = n;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] rim_coord(input logic [31:0] r, input logic [31:0] m,
                                              input logic neg, input logic [31:0] sigma);
        logic [63:0] q;
        q = (64'(r) * 64'(m)) / 64'(sigma);
        if (q > 64'(r)) q = 64'(r);
        return neg ? (~q[31:0] + 32'd1) : q[31:0];
    endfunction

    function automatic t_vec support_point(input t_vec d);
        t_vec        p;
        logic [31:0] mx;
        logic [31:0] mz;
        logic [31:0] r;
        logic [31:0] half;
        logic [31:0] sigma;
        mx    = magnitude(d.x);
        mz    = magnitude(d.z);
        r     = cyl_diameter >> 1;
        half  = cyl_height >> 1;
        sigma = floor_root(64'(mx) * 64'(mx) + 64'(mz) * 64'(mz));
        if (sigma != 0) begin
            p.x = rim_coord(r, mx, d.x[31], sigma);
            p.z = rim_coord(r, mz, d.z[31], sigma);
        end else begin
            // zero horizontal direction gives the axis point
            p.x = '0;
            p.z = '0;
        end
        p.y = (d.y == 0) ? '0 : (d.y[31] ? (~half + 32'd1) : half);
        return p;
    endfunction

    // driver: waits a random gap, then offers the next queued item
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap <= $urandom_range(0, 19);
        end else if (s_tvalid && !s_accepted) begin
            // keep offering the same item
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (dir_queue.size() > 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= dir_queue.pop_front();
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // acceptance seen at the rising edge; prediction happens right there
    always @(posedge i_clk) begin
        s_accepted = i_rst_n && s_tvalid && s_tready;
        if (s_accepted) begin
            point_queue.push_back(support_point(t_vec'(s_tdata)));
            sent_count++;
        end
    end

    // monitor: checks results and drives the receiver's stalls
    int stall_left;
    always @(posedge i_clk) begin
        t_vec got;
        t_vec want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_vec'(m_tdata);
            if (point_queue.size() == 0) begin
                $error("result with nothing expected: %h", m_tdata);
                n_errors++;
            end else begin
                want = point_queue.pop_front();
                if (got.x !== want.x) begin
                    $error("point_x expected %h got %h", want.x, got.x);
                    n_errors++;
                end
                if (got.y !== want.y) begin
                    $error("point_y expected %h got %h", want.y, got.y);
                    n_errors++;
                end
                if (got.z !== want.z) begin
                    $error("point_z expected %h got %h", want.z, got.z);
                    n_errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (hold_request) begin
            // long hold-off so the pipeline fills and stalls its input
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 300) hold_request <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (m_tready && m_tvalid) begin
            // item waiting: either take it at the next edge or draw a stall
            if ($urandom_range(0, 2) == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                stall_left <= $urandom_range(0, 19);
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == AddrDiameter) cyl_diameter = value;
        else if (addr == AddrHeight) cyl_height = value;
    endtask

    task automatic set_cylinder(input logic [31:0] dia, input logic [31:0] hgt);
        reg_write(AddrDiameter, dia);
        reg_write(AddrHeight, hgt);
    endtask

    // wait for every queued item to go out and every result to return
    task automatic drain();
        while (dir_queue.size() > 0 || s_tvalid || point_queue.size() > 0)
            @(posedge i_clk);
        repeat (PipeLatency + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return 32'(int'($urandom_range(0, 8'hff)) - 128);
            4: return 32'(int'($urandom_range(0, 20'hfffff)) - 20'h80000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 4))
            0: return 32'hffff_ffff;
            1: return $urandom_range(0, 3);
            2: return $urandom_range(0, 32'h000a_0000);
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_random(input int count);
        t_vec d;
        repeat (count) begin
            d.x = rand_word();
            d.y = rand_word();
            d.z = rand_word();
            dir_queue.push_back(d);
        end
    endtask

    initial begin
        t_vec d;
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        n_errors     = 0;
        sent_count   = 0;
        hold_cycles  = 0;
        hold_request = 1'b0;
        s_accepted   = 1'b0;
        cyl_diameter = 32'h0002_0000;
        cyl_height   = 32'h0002_0000;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset-value registers, axis cases, extremes and signs
        d = '{z: 0, y: 0, x: 0};                               dir_queue.push_back(d);
        d = '{z: 0, y: 32'h0001_0000, x: 0};                   dir_queue.push_back(d);
        d = '{z: 0, y: -32'sd1, x: 32'h0001_0000};             dir_queue.push_back(d);
        d = '{z: 32'h8000_0000, y: 32'h8000_0000, x: 32'h8000_0000};
        dir_queue.push_back(d);
        d = '{z: 32'h7fff_ffff, y: 32'h7fff_ffff, x: 32'h7fff_ffff};
        dir_queue.push_back(d);
        d = '{z: 32'h8000_0000, y: 1, x: 32'h7fff_ffff};       dir_queue.push_back(d);
        d = '{z: 1, y: 0, x: 0};                               dir_queue.push_back(d);
        d = '{z: 0, y: 1, x: -32'sd1};                         dir_queue.push_back(d);
        d = '{z: 3, y: -32'sd5, x: -32'sd4};                   dir_queue.push_back(d);
        d = '{z: 32'hffff_ffff, y: 32'hffff_ffff, x: 32'hffff_ffff};
        dir_queue.push_back(d);
        drain();

        // extreme register settings, then several random ones
        set_cylinder(32'hffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < 10; i++) dir_queue.push_back(dir_queue.size() == 0 ?
            t_vec'({32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001}) : t_vec'({96{1'b1}}));
        queue_random(20);
        drain();
        set_cylinder('0, '0);
        queue_random(20);
        drain();
        set_cylinder(32'h0000_0001, 32'h0000_0003);
        queue_random(20);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            set_cylinder(rand_size(), rand_size());
            queue_random(240);
            if (phase == 2) begin
                hold_cycles  = 0;
                hold_request = 1'b1;
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// File: cylinder_support_point.f
+incdir+hw/rtl
hw/rtl/csp_pkg.sv
hw/rtl/csp_sqrt_cell.sv
hw/rtl/csp_div_cell.sv
hw/rtl/cylinder_support_point.sv
verif/tb_cylinder_support_point.sv
